FILE: src/rbl_pkg.sv
// ----------------------------------------------------------------------------
// rbl_pkg: shared types and constants of the range bin lookup
// Operation codes, the command word passed from front to back, and helpers.
// ----------------------------------------------------------------------------
package rbl_pkg;

    localparam int MAX_BINS_DEFAULT = 64;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = 1;
    localparam int QCNT_W           = 2;
    localparam int NUM_ARGS         = 8;
    localparam int DATA_W           = 32;
    localparam int INDEX_W          = 6;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;
    localparam int DIMS_W           = 2;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic REG_DIMENSIONS = 1'b0;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd1;
    localparam logic [DIMS_W-1:0] DIMS_TWO   = 2'd2;
    localparam logic [DIMS_W-1:0] DIMS_THREE = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                            op;
        logic [NUM_ARGS-1:0][DATA_W-1:0] arg;
    } cmd_t;

    function automatic logic in_range(logic [2*DATA_W-1:0] entry,
                                      logic [DATA_W-1:0] point);
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] p;
        lo = $signed(entry[2*DATA_W-1:DATA_W]);
        hi = $signed(entry[DATA_W-1:0]);
        p  = $signed(point);
        return (p >= lo) && (p < hi);
    endfunction

endpackage

FILE: src/rbl_ifs.sv
// ----------------------------------------------------------------------------
// rbl_ifs: item and result channels of the range bin lookup
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rbl_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [31:0] low_1;
    logic signed [31:0] high_1;
    logic signed [31:0] low_2;
    logic signed [31:0] high_2;
    logic signed [31:0] low_3;
    logic signed [31:0] high_3;
    logic signed [31:0] bin_mean;
    logic signed [31:0] bin_sigma;
    logic signed [31:0] query_1;
    logic signed [31:0] query_2;
    logic signed [31:0] query_3;

    modport source (
        output valid, mode, low_1, high_1, low_2, high_2, low_3, high_3,
               bin_mean, bin_sigma, query_1, query_2, query_3,
        input  ready
    );
    modport sink (
        input  valid, mode, low_1, high_1, low_2, high_2, low_3, high_3,
               bin_mean, bin_sigma, query_1, query_2, query_3,
        output ready
    );
endinterface

interface rbl_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [5:0]         bin_index;
    logic signed [31:0] found_mean;
    logic signed [31:0] found_sigma;
    logic               table_full;

    modport source (
        output valid, found, bin_index, found_mean, found_sigma, table_full,
        input  ready
    );
    modport sink (
        input  valid, found, bin_index, found_mean, found_sigma, table_full,
        output ready
    );
endinterface

FILE: src/rbl_front.sv
// ----------------------------------------------------------------------------
// rbl_front: item intake and classification
// Accepts item beats, decodes the mode into an operation and packs the
// operands into a command word held in a register until the queue takes it.
// ----------------------------------------------------------------------------
module rbl_front (
    input  logic          clk,
    input  logic          rst_n,
    rbl_in_if.sink        items,
    output rbl_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);

    logic          hold_valid_reg;
    logic          hold_valid_next;
    rbl_pkg::cmd_t hold_cmd_reg;
    rbl_pkg::cmd_t decoded;
    logic          accept;

    assign items.ready = !hold_valid_reg || cmd_ready;
    assign accept      = items.valid && items.ready;
    assign cmd         = hold_cmd_reg;
    assign cmd_valid   = hold_valid_reg;

    always_comb
    begin
        decoded.arg = '0;
        unique case (items.mode)
            rbl_pkg::MODE_CLEAR:
            begin
                decoded.op = rbl_pkg::OP_CLEAR;
            end
            rbl_pkg::MODE_APPEND:
            begin
                decoded.op     = rbl_pkg::OP_APPEND;
                decoded.arg[0] = items.low_1;
                decoded.arg[1] = items.high_1;
                decoded.arg[2] = items.low_2;
                decoded.arg[3] = items.high_2;
                decoded.arg[4] = items.low_3;
                decoded.arg[5] = items.high_3;
                decoded.arg[6] = items.bin_mean;
                decoded.arg[7] = items.bin_sigma;
            end
            rbl_pkg::MODE_LOOKUP:
            begin
                decoded.op     = rbl_pkg::OP_LOOKUP;
                decoded.arg[0] = items.query_1;
                decoded.arg[1] = items.query_2;
                decoded.arg[2] = items.query_3;
            end
            default:
            begin
                decoded.op = rbl_pkg::OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg <= decoded;
        end
    end

endmodule

FILE: src/rbl_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rbl_cmd_fifo: command queue between front and back
// A short first-in first-out queue of command words.
// ----------------------------------------------------------------------------
module rbl_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  rbl_pkg::cmd_t push_cmd,
    output logic          push_ready,
    output logic          pop_valid,
    output rbl_pkg::cmd_t pop_cmd,
    input  logic          pop
);

    rbl_pkg::cmd_t                 entry_reg [rbl_pkg::QUEUE_DEPTH];
    logic [rbl_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [rbl_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [rbl_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [rbl_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [rbl_pkg::QCNT_W-1:0]    count_reg;
    logic [rbl_pkg::QCNT_W-1:0]    count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != rbl_pkg::QCNT_W'(rbl_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rbl_pkg::QCNT_W'(rbl_pkg::QUEUE_DEPTH))
        else $error("command queue holds more entries than it has");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("command popped from an empty queue");

endmodule

FILE: src/rbl_back.sv
// ----------------------------------------------------------------------------
// rbl_back: bin table and lookup engine
// Executes clear, append and lookup commands against the bin memories.
// A lookup reads one bin a cycle and stops at the first containing bin.
// ----------------------------------------------------------------------------
module rbl_back #(
    parameter int MAX_BINS = rbl_pkg::MAX_BINS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rbl_pkg::cmd_t              cmd,
    input  logic                       cmd_valid,
    output logic                       cmd_pop,
    input  logic [rbl_pkg::DIMS_W-1:0] dimensions,
    rbl_out_if.source                  results
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int DW    = rbl_pkg::DATA_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [2*DW-1:0] rng1_mem [MAX_BINS];
    logic [2*DW-1:0] rng2_mem [MAX_BINS];
    logic [2*DW-1:0] rng3_mem [MAX_BINS];
    logic [2*DW-1:0] pay_mem  [MAX_BINS];
    logic [2*DW-1:0] rng1_rd_reg;
    logic [2*DW-1:0] rng2_rd_reg;
    logic [2*DW-1:0] rng3_rd_reg;
    logic [2*DW-1:0] pay_rd_reg;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [2:0][DW-1:0] query_reg;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_found_reg;
    logic                        out_found_next;
    logic [rbl_pkg::INDEX_W-1:0] out_index_reg;
    logic [rbl_pkg::INDEX_W-1:0] out_index_next;
    logic [DW-1:0]               out_mean_reg;
    logic [DW-1:0]               out_mean_next;
    logic [DW-1:0]               out_sigma_reg;
    logic [DW-1:0]               out_sigma_next;
    logic                        out_full_reg;
    logic                        out_full_next;

    logic             out_free;
    logic             room;
    logic             issue;
    logic             hit;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      idx_wide;

    assign out_free = !out_valid_reg || results.ready;
    assign room     = fill_reg < CNT_W'(MAX_BINS);
    assign issue    = (state_reg == ST_SCAN) && (scan_reg < fill_reg);
    assign wr_addr  = fill_reg[IDX_W-1:0];
    assign rd_addr  = scan_reg[IDX_W-1:0];
    assign idx_wide = 32'(rd_idx_reg);

    assign hit = rd_valid_reg && (dimensions != '0)
               && rbl_pkg::in_range(rng1_rd_reg, query_reg[0])
               && ((dimensions < rbl_pkg::DIMS_TWO)
                   || rbl_pkg::in_range(rng2_rd_reg, query_reg[1]))
               && ((dimensions < rbl_pkg::DIMS_THREE)
                   || rbl_pkg::in_range(rng3_rd_reg, query_reg[2]));

    assign results.valid       = out_valid_reg;
    assign results.found       = out_found_reg;
    assign results.bin_index   = out_index_reg;
    assign results.found_mean  = out_mean_reg;
    assign results.found_sigma = out_sigma_reg;
    assign results.table_full  = out_full_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        rd_valid_next  = rd_valid_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        out_mean_next  = out_mean_reg;
        out_sigma_next = out_sigma_reg;
        out_full_next  = out_full_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        rbl_pkg::OP_LOOKUP:
                        begin
                            scan_next     = '0;
                            rd_valid_next = 1'b0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_found_next = 1'b0;
                            out_index_next = '0;
                            out_mean_next  = '0;
                            out_sigma_next = '0;
                            out_full_next  = 1'b0;
                            if (cmd.op == rbl_pkg::OP_CLEAR)
                            begin
                                fill_next = '0;
                            end
                            else if (cmd.op == rbl_pkg::OP_APPEND)
                            begin
                                out_full_next = !room;
                                if (room)
                                begin
                                    wr_en     = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_valid_next = issue;
                if (issue)
                begin
                    scan_next = scan_reg + 1'b1;
                end
                if (hit || !issue)
                begin
                    out_valid_next = 1'b1;
                    out_full_next  = 1'b0;
                    out_found_next = hit;
                    out_index_next = hit ? idx_wide[rbl_pkg::INDEX_W-1:0] : '0;
                    out_mean_next  = hit ? pay_rd_reg[2*DW-1:DW] : '0;
                    out_sigma_next = hit ? pay_rd_reg[DW-1:0] : '0;
                    rd_valid_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_mean_reg  <= out_mean_next;
        out_sigma_reg <= out_sigma_next;
        out_full_reg  <= out_full_next;
        rd_idx_reg    <= rd_addr;
        if (cmd_pop && (cmd.op == rbl_pkg::OP_LOOKUP))
        begin
            query_reg <= cmd.arg[2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rng1_mem[wr_addr] <= {cmd.arg[0], cmd.arg[1]};
            rng2_mem[wr_addr] <= {cmd.arg[2], cmd.arg[3]};
            rng3_mem[wr_addr] <= {cmd.arg[4], cmd.arg[5]};
            pay_mem[wr_addr]  <= {cmd.arg[6], cmd.arg[7]};
        end
        rng1_rd_reg <= rng1_mem[rd_addr];
        rng2_rd_reg <= rng2_mem[rd_addr];
        rng3_rd_reg <= rng3_mem[rd_addr];
        pay_rd_reg  <= pay_mem[rd_addr];
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_BINS))
        else $error("bin count exceeds the table size");

    a_scan_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !out_valid_reg)
        else $error("result register occupied during a scan");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("bin read marked valid outside a scan");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_found_reg && out_full_reg))
        else $error("result flags both a match and a full table");

endmodule

FILE: src/range_bin_lookup.sv
// ----------------------------------------------------------------------------
// range_bin_lookup: first-match lookup in a table of multidimensional bins
// Top level: configuration register, front end, command queue and back end.
// ----------------------------------------------------------------------------
// A clear or an append passes through the front's command register, the
// queue and the result register. A lookup reads the bin memories one bin
// per cycle and stops early at the first match. Clears and appends can
// follow one per cycle while results are taken; a lookup holds the back
// end until it is done, and the queue absorbs two more items meanwhile.
// Reset empties the table and sets dimensions to one; bin contents are
// not cleared and stay unread until written again.
// ----------------------------------------------------------------------------
module range_bin_lookup #(
    parameter int MAX_BINS = rbl_pkg::MAX_BINS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rbl_in_if.sink                      items,
    rbl_out_if.source                   results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rbl_pkg::PADDR_W-1:0] paddr,
    input  logic [rbl_pkg::PDATA_W-1:0] pwdata,
    output logic [rbl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [rbl_pkg::DIMS_W-1:0] dims_reg;
    logic [rbl_pkg::DIMS_W-1:0] dims_next;
    logic                       reg_sel;

    rbl_pkg::cmd_t front_cmd;
    logic          front_valid;
    logic          queue_ready;
    rbl_pkg::cmd_t back_cmd;
    logic          back_valid;
    logic          back_pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == rbl_pkg::REG_DIMENSIONS);

    always_comb
    begin
        dims_next = dims_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            dims_next = pwdata[rbl_pkg::DIMS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = rbl_pkg::PDATA_W'(dims_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= rbl_pkg::DIMS_RESET;
        end
        else
        begin
            dims_reg <= dims_next;
        end
    end

    rbl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (queue_ready)
    );

    rbl_cmd_fifo u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (queue_ready),
        .pop_valid  (back_valid),
        .pop_cmd    (back_cmd),
        .pop        (back_pop)
    );

    rbl_back #(
        .MAX_BINS (MAX_BINS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (back_cmd),
        .cmd_valid  (back_valid),
        .cmd_pop    (back_pop),
        .dimensions (dims_reg),
        .results    (results)
    );

endmodule
